FILE: src/sust_pkg.sv
// Package for the sorted unique set table: capacity, derived widths,
// command and status codes, sequencer states and the cell control struct.
// No dependencies.
`default_nettype none

package sust_pkg;

	// Number of cells, one identifier each.
	localparam int unsigned CAPACITY = 32;
	// Width of the fill count, which must be able to hold CAPACITY itself.
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
	localparam int unsigned ID_W     = 16;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned STAT_W   = 3;
	localparam int unsigned LEN_W    = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED = 3'd0,
		STAT_PRESENT  = 3'd1,
		STAT_REMOVED  = 3'd2,
		STAT_ABSENT   = 3'd3,
		STAT_FULL     = 3'd4,
		STAT_READ_OK  = 3'd5,
		STAT_BEYOND   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_CMP,
		SEQ_UPD
	} seq_state_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic cmp_en;  // capture compare flags and read tap
		logic ins;     // open a slot at the sorted place and write the identifier
		logic rem;     // close the gap at the matching entry
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/sust_cell.sv
// One storage cell of the sorted set table: holds one identifier, compares it
// against the broadcast identifier and shifts with its neighbours.
// Depends on sust_pkg.
`default_nettype none

module sust_cell (
	input  wire logic                          clk,
	input  wire sust_pkg::cell_ctl_t           ctl,
	input  wire logic [sust_pkg::ID_W-1:0]     id,
	input  wire logic                          occ,
	input  wire logic                          rd_hit,
	input  wire logic                          left_lt,
	input  wire logic [sust_pkg::ID_W-1:0]     left_value,
	input  wire logic [sust_pkg::ID_W-1:0]     right_value,
	output logic      [sust_pkg::ID_W-1:0]     value,
	output logic                               lt,
	output logic                               eq,
	output logic      [sust_pkg::ID_W-1:0]     rd_value
);

	logic [sust_pkg::ID_W-1:0] value_q;
	logic                      lt_q;
	logic                      eq_q;
	logic [sust_pkg::ID_W-1:0] rd_q;

	// Compare stage: flags are only meaningful for occupied cells.
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			lt_q <= occ && (value_q < id);
			eq_q <= occ && (value_q == id);
			rd_q <= rd_hit ? value_q : '0;
		end
	end

	// Update stage: every cell at or above the sorted place moves together.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			value_q <= left_lt ? id : left_value;
		end else if (ctl.rem && !lt_q) begin
			value_q <= right_value;
		end
	end

	assign value    = value_q;
	assign lt       = lt_q;
	assign eq       = eq_q;
	assign rd_value = rd_q;

endmodule

`default_nettype wire

FILE: src/sorted_unique_set_table_core.sv
// Top level of the sorted unique set table: sequencer, fill count, result
// register and the row of sust_cell instances.
// Depends on sust_pkg and sust_cell.
//
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   cmd, component, index
// result    out        out_valid / out_ready status, entry_value, set_length
//
// Each request passes through acceptance, a compare state in which every
// cell compares its entry with the identifier in parallel, and an update state
// in which the cells shift together and the result register is loaded.
// The update waits while the result register still holds an untaken result.
// A new request is accepted while the previous result waits to be taken.
// Reset clears the fill count, the result valid and the sequencer; cell contents are not reset.
`default_nettype none

module sorted_unique_set_table_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [sust_pkg::CMD_W-1:0]      cmd,
	input  wire logic [sust_pkg::ID_W-1:0]       component,
	input  wire logic [sust_pkg::IDX_W-1:0]      index,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [sust_pkg::STAT_W-1:0]     status,
	output logic      [sust_pkg::ID_W-1:0]       entry_value,
	output logic      [sust_pkg::LEN_W-1:0]      set_length
);

	sust_pkg::seq_state_t              state_q;
	sust_pkg::seq_state_t              state_d;
	logic [sust_pkg::CMD_W-1:0]        cmd_q;
	logic [sust_pkg::ID_W-1:0]         id_q;
	logic [sust_pkg::IDX_W-1:0]        idx_q;
	logic [sust_pkg::CNT_W-1:0]        count_q;
	logic [sust_pkg::CNT_W-1:0]        count_d;
	logic                              out_valid_q;
	logic [sust_pkg::STAT_W-1:0]       status_q;
	logic [sust_pkg::ID_W-1:0]         entry_value_q;
	logic [sust_pkg::LEN_W-1:0]        set_length_q;

	sust_pkg::cell_ctl_t               ctl;
	logic                              cmp_en;
	logic                              ins_en;
	logic                              rem_en;
	logic                              accept;
	logic                              slot_free;
	logic                              commit;
	logic                              found;
	logic                              full;
	logic                              idx_ok;
	logic [sust_pkg::ID_W-1:0]         rd_any;
	sust_pkg::status_t                 status_d;
	logic [sust_pkg::ID_W-1:0]         entry_value_d;

	logic [sust_pkg::CAPACITY-1:0]     occ;
	logic [sust_pkg::CAPACITY-1:0]     rd_hit;
	logic [sust_pkg::CAPACITY-1:0]     lt;
	logic [sust_pkg::CAPACITY-1:0]     eq;
	logic [sust_pkg::ID_W-1:0]         value    [sust_pkg::CAPACITY];
	logic [sust_pkg::ID_W-1:0]         rd_value [sust_pkg::CAPACITY];

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign commit    = (state_q == sust_pkg::SEQ_UPD) && slot_free;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sust_pkg::SEQ_IDLE: begin
				if (in_valid) state_d = sust_pkg::SEQ_CMP;
			end
			sust_pkg::SEQ_CMP: begin
				state_d = sust_pkg::SEQ_UPD;
			end
			sust_pkg::SEQ_UPD: begin
				if (slot_free) state_d = sust_pkg::SEQ_IDLE;
			end
			default: begin
				state_d = sust_pkg::SEQ_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		cmp_en   = 1'b0;
		unique case (state_q)
			sust_pkg::SEQ_IDLE: in_ready = 1'b1;
			sust_pkg::SEQ_CMP:  cmp_en   = 1'b1;
			sust_pkg::SEQ_UPD:  ;
			default:            ;
		endcase
	end

	// Control word broadcast to every cell.
	assign ctl = '{cmp_en: cmp_en, ins: ins_en, rem: rem_en};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sust_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			id_q  <= component;
			idx_q <= index;
		end
	end

	// Per-cell occupancy and read select, from the cell's fixed position.
	always_comb begin
		for (int i = 0; i < sust_pkg::CAPACITY; i++) begin
			occ[i]    = 32'(i) < 32'(count_q);
			rd_hit[i] = 32'(i) == 32'(idx_q);
		end
	end

	// Gather the row's flags and the read tap.
	always_comb begin
		found  = |eq;
		rd_any = '0;
		for (int i = 0; i < sust_pkg::CAPACITY; i++) begin
			rd_any = rd_any | rd_value[i];
		end
	end

	assign full   = count_q == sust_pkg::CNT_W'(sust_pkg::CAPACITY);
	assign idx_ok = 32'(idx_q) < 32'(count_q);

	// Decide the outcome of the request held in the update cycle.
	always_comb begin
		status_d      = sust_pkg::STAT_BEYOND;
		entry_value_d = '0;
		count_d       = count_q;
		ins_en        = 1'b0;
		rem_en        = 1'b0;
		unique case (cmd_q)
			sust_pkg::CMD_ADD: begin
				if (found) begin
					status_d = sust_pkg::STAT_PRESENT;
				end else if (full) begin
					status_d = sust_pkg::STAT_FULL;
				end else begin
					status_d = sust_pkg::STAT_INSERTED;
					ins_en   = commit;
					count_d  = count_q + 1'b1;
				end
			end
			sust_pkg::CMD_REMOVE: begin
				if (found) begin
					status_d = sust_pkg::STAT_REMOVED;
					rem_en   = commit;
					count_d  = count_q - 1'b1;
				end else begin
					status_d = sust_pkg::STAT_ABSENT;
				end
			end
			sust_pkg::CMD_READ: begin
				if (idx_ok) begin
					status_d      = sust_pkg::STAT_READ_OK;
					entry_value_d = rd_any;
				end
			end
			default: ;
		endcase
	end

	// Fill count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q      <= status_d;
			entry_value_q <= entry_value_d;
			set_length_q  <= sust_pkg::LEN_W'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_value = entry_value_q;
	assign set_length  = set_length_q;

	// Row of cells; each sees its neighbours' entries for shifting.
	for (genvar g = 0; g < sust_pkg::CAPACITY; g++) begin : g_cell
		logic                      left_lt;
		logic [sust_pkg::ID_W-1:0] left_value;
		logic [sust_pkg::ID_W-1:0] right_value;

		if (g == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_value = id_q;
		end else begin : g_mid
			assign left_lt    = lt[g-1];
			assign left_value = value[g-1];
		end

		if (g == sust_pkg::CAPACITY - 1) begin : g_last
			assign right_value = '0;
		end else begin : g_inner
			assign right_value = value[g+1];
		end

		sust_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.id          (id_q),
			.occ         (occ[g]),
			.rd_hit      (rd_hit[g]),
			.left_lt     (left_lt),
			.left_value  (left_value),
			.right_value (right_value),
			.value       (value[g]),
			.lt          (lt[g]),
			.eq          (eq[g]),
			.rd_value    (rd_value[g])
		);
	end

endmodule

`default_nettype wire
